>>> hw/rtl/gdda_pkg.sv
// Types and constants shared by the grid DDA ray traversal modules.
`timescale 1ns / 1ps

package gdda_pkg;

   // Request types
   localparam logic REQ_TILE = 1'b0;
   localparam logic REQ_CAST = 1'b1;

   // Tile kinds as stored
   localparam logic [1:0] TILE_EMPTY = 2'd0;
   localparam logic [1:0] TILE_WALL  = 2'd1;
   localparam logic [1:0] TILE_CLEAR = 2'd2;

   // Result kinds
   localparam logic [1:0] HIT_NONE   = 2'd0;
   localparam logic [1:0] HIT_WALL   = 2'd1;
   localparam logic [1:0] HIT_CLEAR  = 2'd2;
   localparam logic [1:0] HIT_SPRITE = 2'd3;

   // Faces
   localparam logic [1:0] FACE_ROW_NEG = 2'd0;
   localparam logic [1:0] FACE_ROW_POS = 2'd1;
   localparam logic [1:0] FACE_COL_NEG = 2'd2;
   localparam logic [1:0] FACE_COL_POS = 2'd3;

   localparam int CSR_DATA_BITS = 7;
   localparam int HIT_DEPTH_BITS = 32;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH   = 2'd0,
      CSR_MAP_HEIGHT  = 2'd1,
      CSR_WALL_MASK   = 2'd2,
      CSR_SPRITE_MASK = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_EVAL,
      ST_SPRITE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_PRIMARY,
      EMIT_SPRITE
   } emit_sel_type;

   typedef struct packed {
      logic [6:0] map_width;
      logic [6:0] map_height;
      logic       wall_on;
      logic       sprite_on;
   } cfg_type;

   typedef struct packed {
      logic         clr_wr;
      logic         tile_wr;
      logic         cast_load;
      logic         step;
      logic         emit;
      emit_sel_type sel;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic oob;
      logic rpt_primary;
      logic stop_wall;
      logic rpt_sprite;
      logic at_limit;
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/gdda_ctrl.sv
// Controller state machine: memory clear, item intake, step and report sequencing.
`timescale 1ns / 1ps

module gdda_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_type,
   output logic                    req_stall,
   input  gdda_pkg::dp_status_type status,
   output gdda_pkg::dp_cmd_type    cmd
);

   gdda_pkg::ctrl_state_type state_ff;
   gdda_pkg::ctrl_state_type state_in;
   logic                     primary_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdda_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign primary_last = status.stop_wall || status.at_limit;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.sel       = gdda_pkg::EMIT_NONE;
      req_stall     = 1'b1;
      unique case (state_ff)
         gdda_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = gdda_pkg::ST_IDLE;
            end
         end
         gdda_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type == gdda_pkg::REQ_CAST) begin
                  cmd.cast_load = 1'b1;
                  state_in      = gdda_pkg::ST_STEP;
               end else begin
                  cmd.tile_wr = 1'b1;
               end
            end
         end
         gdda_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            state_in = gdda_pkg::ST_EVAL;
         end
         gdda_pkg::ST_EVAL: begin
            if (status.oob) begin
               // left the grid: one final item
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = gdda_pkg::EMIT_NONE;
                  cmd.last = 1'b1;
                  state_in = gdda_pkg::ST_IDLE;
               end
            end else if (status.rpt_primary) begin
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = gdda_pkg::EMIT_PRIMARY;
                  cmd.last = primary_last;
                  if (primary_last) begin
                     state_in = gdda_pkg::ST_IDLE;
                  end else if (status.rpt_sprite) begin
                     state_in = gdda_pkg::ST_SPRITE;
                  end else begin
                     state_in = gdda_pkg::ST_STEP;
                  end
               end
            end else if (status.rpt_sprite) begin
               state_in = gdda_pkg::ST_SPRITE;
            end else begin
               state_in = gdda_pkg::ST_STEP;
            end
         end
         gdda_pkg::ST_SPRITE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = gdda_pkg::EMIT_SPRITE;
               cmd.last = status.at_limit;
               state_in = status.at_limit ? gdda_pkg::ST_IDLE : gdda_pkg::ST_STEP;
            end
         end
         default: begin
            state_in = gdda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/gdda_dp.sv
// Datapath: tile memory, DDA step registers, saturating distances and result register.
`timescale 1ns / 1ps

module gdda_dp #(
   parameter int GRID_DIM  = 64,
   parameter int MAX_HITS  = 16,
   parameter int DIST_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gdda_pkg::cfg_type        cfg,
   input  gdda_pkg::dp_cmd_type     cmd,
   output gdda_pkg::dp_status_type  status,
   input  logic [5:0]               req_cell_x,
   input  logic [5:0]               req_cell_y,
   input  logic [1:0]               req_tile_kind,
   input  logic                     req_tile_sprite,
   input  logic [31:0]              req_side_x,
   input  logic [31:0]              req_side_y,
   input  logic [31:0]              req_delta_x,
   input  logic [31:0]              req_delta_y,
   input  logic                     req_step_x_neg,
   input  logic                     req_step_y_neg,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_hit_kind,
   output logic [5:0]               rsp_hit_x,
   output logic [5:0]               rsp_hit_y,
   output logic [31:0]              rsp_hit_depth,
   output logic [1:0]               rsp_hit_face,
   output logic                     rsp_last
);

   localparam int DEPTH = GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(DEPTH);
   // coordinate width: holds the largest start cell plus one and keeps -1 above any size
   localparam int CW    = $clog2(((GRID_DIM > 64) ? GRID_DIM : 64) + 2);
   localparam int SW    = ((DIST_BITS > 32) ? DIST_BITS : 32) + 1;
   localparam int CNTW  = $clog2(MAX_HITS + 1);

   localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;
   localparam logic [CW-1:0]        COORD_ONE = CW'(1);
   localparam logic [CW-1:0]        COORD_NEG = '1;
   localparam logic [CW-1:0]        DIM_C     = CW'(GRID_DIM);
   localparam logic [AW-1:0]        DIM_A     = AW'(GRID_DIM);
   localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CNTW-1:0]      LIMIT_M1  = CNTW'(MAX_HITS - 1);
   localparam logic [SW-1:0]        OUT_MAX   = SW'({gdda_pkg::HIT_DEPTH_BITS{1'b1}});

   logic [2:0]           tile_mem [DEPTH];
   logic [2:0]           tile_rd_ff;
   logic [AW-1:0]        clr_addr_ff;

   logic [CW-1:0]        col_ff, row_ff;
   logic [CW-1:0]        w_ff, h_ff;
   logic [DIST_BITS-1:0] dist_x_ff, dist_y_ff, depth_ff;
   logic [31:0]          delta_x_ff, delta_y_ff;
   logic                 xneg_ff, yneg_ff;
   logic [1:0]           face_ff;
   logic                 oob_ff;
   logic [CNTW-1:0]      cnt_ff;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_kind_ff;
   logic [5:0]           rsp_x_ff, rsp_y_ff;
   logic [31:0]          rsp_depth_ff;
   logic [1:0]           rsp_face_ff;
   logic                 rsp_last_ff;

   logic                 take_x;
   logic [CW-1:0]        col_nx, row_nx;
   logic [SW-1:0]        sum_x, sum_y;
   logic [DIST_BITS-1:0] sat_x, sat_y;
   logic [AW-1:0]        rd_addr, wr_addr, tile_addr;
   logic [2:0]           wr_data;
   logic                 wr_en;
   logic                 tile_in_grid;
   logic [1:0]           tile_kind_fix;
   logic [CW-1:0]        w_cfg, h_cfg;
   logic [SW-1:0]        depth_ext;
   logic [31:0]          depth_out;
   logic                 cls_clear, cls_wall, spr;
   logic                 out_free;

   // ---------------------------------------------------------------- step logic
   assign take_x = dist_x_ff < dist_y_ff;
   assign col_nx = take_x ? col_ff + (xneg_ff ? COORD_NEG : COORD_ONE) : col_ff;
   assign row_nx = take_x ? row_ff : row_ff + (yneg_ff ? COORD_NEG : COORD_ONE);
   assign rd_addr = AW'(row_nx) * DIM_A + AW'(col_nx);

   assign sum_x = SW'(dist_x_ff) + SW'(delta_x_ff);
   assign sum_y = SW'(dist_y_ff) + SW'(delta_y_ff);
   assign sat_x = (sum_x > SW'(DIST_MAX)) ? DIST_MAX : sum_x[DIST_BITS-1:0];
   assign sat_y = (sum_y > SW'(DIST_MAX)) ? DIST_MAX : sum_y[DIST_BITS-1:0];

   // clamp size registers to the grid
   assign w_cfg = (CW'(cfg.map_width) > DIM_C) ? DIM_C : CW'(cfg.map_width);
   assign h_cfg = (CW'(cfg.map_height) > DIM_C) ? DIM_C : CW'(cfg.map_height);

   always_ff @(posedge clock) begin
      if (cmd.cast_load) begin
         col_ff     <= CW'(req_cell_x);
         row_ff     <= CW'(req_cell_y);
         dist_x_ff  <= DIST_BITS'(req_side_x);
         dist_y_ff  <= DIST_BITS'(req_side_y);
         delta_x_ff <= req_delta_x;
         delta_y_ff <= req_delta_y;
         xneg_ff    <= req_step_x_neg;
         yneg_ff    <= req_step_y_neg;
         w_ff       <= w_cfg;
         h_ff       <= h_cfg;
      end else if (cmd.step) begin
         col_ff <= col_nx;
         row_ff <= row_nx;
         oob_ff <= (col_nx >= w_ff) || (row_nx >= h_ff);
         if (take_x) begin
            depth_ff  <= dist_x_ff;
            dist_x_ff <= sat_x;
            face_ff   <= xneg_ff ? gdda_pkg::FACE_COL_NEG : gdda_pkg::FACE_COL_POS;
         end else begin
            depth_ff  <= dist_y_ff;
            dist_y_ff <= sat_y;
            face_ff   <= yneg_ff ? gdda_pkg::FACE_ROW_NEG : gdda_pkg::FACE_ROW_POS;
         end
      end
   end

   // ---------------------------------------------------------------- tile memory
   assign tile_in_grid  = (CW'(req_cell_x) < DIM_C) && (CW'(req_cell_y) < DIM_C);
   assign tile_kind_fix = (req_tile_kind == gdda_pkg::TILE_WALL ||
                           req_tile_kind == gdda_pkg::TILE_CLEAR) ?
                          req_tile_kind : gdda_pkg::TILE_EMPTY;
   assign tile_addr     = AW'(req_cell_y) * DIM_A + AW'(req_cell_x);

   assign wr_en   = cmd.clr_wr || (cmd.tile_wr && tile_in_grid);
   assign wr_addr = cmd.clr_wr ? clr_addr_ff : tile_addr;
   assign wr_data = cmd.clr_wr ? {1'b0, gdda_pkg::TILE_EMPTY} : {req_tile_sprite, tile_kind_fix};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tile_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         tile_rd_ff <= tile_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // ---------------------------------------------------------------- classify
   assign spr       = tile_rd_ff[2];
   assign cls_clear = tile_rd_ff[1:0] == gdda_pkg::TILE_CLEAR;
   assign cls_wall  = !cls_clear && !spr && (tile_rd_ff[1:0] == gdda_pkg::TILE_WALL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status             = '0;
      status.clr_done    = clr_addr_ff == LAST_ADDR;
      status.oob         = oob_ff;
      status.rpt_primary = cfg.wall_on && (cls_wall || cls_clear);
      status.stop_wall   = cfg.wall_on && cls_wall;
      status.rpt_sprite  = cfg.sprite_on && spr;
      status.at_limit    = cnt_ff == LIMIT_M1;
      status.out_free    = out_free;
   end

   // ---------------------------------------------------------------- result register
   assign depth_ext = SW'(depth_ff);
   assign depth_out = (depth_ext > OUT_MAX) ? '1 : depth_ext[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.cast_load) begin
            cnt_ff <= '0;
         end else if (cmd.emit) begin
            cnt_ff <= cnt_ff + CNTW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_depth_ff <= depth_out;
         rsp_face_ff  <= face_ff;
         rsp_last_ff  <= cmd.last;
         case (cmd.sel)
            gdda_pkg::EMIT_PRIMARY: begin
               rsp_kind_ff <= cls_clear ? gdda_pkg::HIT_CLEAR : gdda_pkg::HIT_WALL;
               rsp_x_ff    <= col_ff[5:0];
               rsp_y_ff    <= row_ff[5:0];
            end
            gdda_pkg::EMIT_SPRITE: begin
               rsp_kind_ff <= gdda_pkg::HIT_SPRITE;
               rsp_x_ff    <= col_ff[5:0];
               rsp_y_ff    <= row_ff[5:0];
            end
            default: begin
               rsp_kind_ff <= gdda_pkg::HIT_NONE;
               rsp_x_ff    <= '0;
               rsp_y_ff    <= '0;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_kind  = rsp_kind_ff;
   assign rsp_hit_x     = rsp_x_ff;
   assign rsp_hit_y     = rsp_y_ff;
   assign rsp_hit_depth = rsp_depth_ff;
   assign rsp_hit_face  = rsp_face_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> hw/rtl/grid_dda_ray_traversal_top.sv
// Top level of the grid DDA ray traversal block: registers, controller and datapath.
`timescale 1ns / 1ps

// After reset the block sweeps its tile memory to empty, one tile a cycle, over
// all GRID_DIM*GRID_DIM tiles (4096 at the default), and takes no item until
// done; register writes are taken throughout. A tile-write item is written while
// idle and leaves the block idle. A cast item is loaded, then each cell the ray
// visits is stepped with a tile memory read and then evaluated, with a further
// sprite step for a cell that gives a sprite item; a run is bounded by about
// 2*GRID_DIM cells, set by the map width and height. The evaluate and sprite
// steps also wait while the result register is full and stalled. The next item
// is accepted as soon as the last result of a cast sits in the result register.
module grid_dda_ray_traversal_top #(
   parameter int GRID_DIM  = 64,
   parameter int MAX_HITS  = 16,
   parameter int DIST_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [gdda_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [1:0]  req_tile_kind,
   input  logic        req_tile_sprite,
   input  logic [31:0] req_side_x,
   input  logic [31:0] req_side_y,
   input  logic [31:0] req_delta_x,
   input  logic [31:0] req_delta_y,
   input  logic        req_step_x_neg,
   input  logic        req_step_y_neg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_hit_kind,
   output logic [5:0]  rsp_hit_x,
   output logic [5:0]  rsp_hit_y,
   output logic [31:0] rsp_hit_depth,
   output logic [1:0]  rsp_hit_face,
   output logic        rsp_last
);

   gdda_pkg::cfg_type       cfg_ff;
   gdda_pkg::dp_cmd_type    cmd;
   gdda_pkg::dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width  <= 7'd64;
         cfg_ff.map_height <= 7'd64;
         cfg_ff.wall_on    <= 1'b1;
         cfg_ff.sprite_on  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            gdda_pkg::CSR_MAP_WIDTH:   cfg_ff.map_width  <= csr_wdata;
            gdda_pkg::CSR_MAP_HEIGHT:  cfg_ff.map_height <= csr_wdata;
            gdda_pkg::CSR_WALL_MASK:   cfg_ff.wall_on    <= csr_wdata[0];
            gdda_pkg::CSR_SPRITE_MASK: cfg_ff.sprite_on  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   gdda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gdda_dp #(
      .GRID_DIM  (GRID_DIM),
      .MAX_HITS  (MAX_HITS),
      .DIST_BITS (DIST_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_tile_kind   (req_tile_kind),
      .req_tile_sprite (req_tile_sprite),
      .req_side_x      (req_side_x),
      .req_side_y      (req_side_y),
      .req_delta_x     (req_delta_x),
      .req_delta_y     (req_delta_y),
      .req_step_x_neg  (req_step_x_neg),
      .req_step_y_neg  (req_step_y_neg),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit_kind    (rsp_hit_kind),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_hit_depth   (rsp_hit_depth),
      .rsp_hit_face    (rsp_hit_face),
      .rsp_last        (rsp_last)
   );

endmodule

>>> dv/grid_dda_ray_traversal_top_tb.sv
// Self-checking testbench for the grid DDA ray traversal block.
`timescale 1ns / 1ps

module grid_dda_ray_traversal_top_tb;

   localparam int GRID          = 64;
   localparam int HIT_LIMIT     = 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 20;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 400000;
   // kind code outside the legal set; the block stores it as empty
   localparam logic [1:0] TILE_BAD = 2'd3;

   typedef struct {
      logic        rtype;
      logic [5:0]  cx;
      logic [5:0]  cy;
      logic [1:0]  tkind;
      logic        tspr;
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] dx;
      logic [31:0] dy;
      logic        xneg;
      logic        yneg;
   } ray_req_type;

   typedef struct {
      logic [1:0]  kind;
      logic [5:0]  x;
      logic [5:0]  y;
      logic [31:0] depth;
      logic [1:0]  face;
      logic        last;
   } hit_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        csr_we          = 1'b0;
   logic [1:0]  csr_index       = '0;
   logic [6:0]  csr_wdata       = '0;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_type        = 1'b0;
   logic [5:0]  req_cell_x      = '0;
   logic [5:0]  req_cell_y      = '0;
   logic [1:0]  req_tile_kind   = '0;
   logic        req_tile_sprite = 1'b0;
   logic [31:0] req_side_x      = '0;
   logic [31:0] req_side_y      = '0;
   logic [31:0] req_delta_x     = '0;
   logic [31:0] req_delta_y     = '0;
   logic        req_step_x_neg  = 1'b0;
   logic        req_step_y_neg  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_hit_kind;
   logic [5:0]  rsp_hit_x;
   logic [5:0]  rsp_hit_y;
   logic [31:0] rsp_hit_depth;
   logic [1:0]  rsp_hit_face;
   logic        rsp_last;

   // shadow of the block's tile grid and registers
   logic [2:0]  tile_mem [0:GRID*GRID-1];
   logic [6:0]  cfg_width  = 7'd64;
   logic [6:0]  cfg_height = 7'd64;
   logic        cfg_wall   = 1'b1;
   logic        cfg_sprite = 1'b0;

   hit_type     pending_hits [$];
   int          fail_cnt      = 0;
   int          n_tiles       = 0;
   int          n_casts       = 0;
   int          n_hits        = 0;
   int          n_settings    = 0;
   int          cycle_cnt     = 0;
   bit          sender_idle_on = 1'b1;
   bit          rsp_idle_on    = 1'b1;
   bit          rsp_hold_req   = 1'b0;
   int unsigned rsp_hold_left  = 0;
   int unsigned rsp_gap_left   = 0;

   grid_dda_ray_traversal_top uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_tile_kind   (req_tile_kind),
      .req_tile_sprite (req_tile_sprite),
      .req_side_x      (req_side_x),
      .req_side_y      (req_side_y),
      .req_delta_x     (req_delta_x),
      .req_delta_y     (req_delta_y),
      .req_step_x_neg  (req_step_x_neg),
      .req_step_y_neg  (req_step_y_neg),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit_kind    (rsp_hit_kind),
      .rsp_hit_x       (rsp_hit_x),
      .rsp_hit_y       (rsp_hit_y),
      .rsp_hit_depth   (rsp_hit_depth),
      .rsp_hit_face    (rsp_hit_face),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] sat_dist(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic hit_type make_hit(input logic [1:0] kind, input int col, input int row,
                                        input logic [31:0] depth, input logic [1:0] face);
      hit_type h;
      h.kind  = kind;
      h.x     = col[5:0];
      h.y     = row[5:0];
      h.depth = depth;
      h.face  = face;
      h.last  = 1'b0;
      return h;
   endfunction

   // Update the shadow grid for a tile write, or walk the ray and queue its hits.
   function automatic void trace_item(input ray_req_type r);
      hit_type     run [$];
      int          w;
      int          hgt;
      int          col;
      int          row;
      logic [31:0] dist_x;
      logic [31:0] dist_y;
      logic [31:0] depth;
      logic [1:0]  face;
      logic [1:0]  tkind;
      logic [1:0]  cls;
      logic [2:0]  t;
      logic        spr;
      logic        done;
      if (r.rtype == gdda_pkg::REQ_TILE) begin
         tkind = (r.tkind == TILE_BAD) ? gdda_pkg::TILE_EMPTY : r.tkind;
         tile_mem[{r.cy, r.cx}] = {r.tspr, tkind};
         return;
      end
      w      = (cfg_width > GRID) ? GRID : int'(cfg_width);
      hgt    = (cfg_height > GRID) ? GRID : int'(cfg_height);
      col    = int'(r.cx);
      row    = int'(r.cy);
      dist_x = r.sx;
      dist_y = r.sy;
      depth  = '0;
      face   = gdda_pkg::FACE_ROW_NEG;
      done   = 1'b0;
      for (int iter = 0; iter < 4 * GRID + 8 && !done; iter++) begin
         // ties step in y
         if (dist_x < dist_y) begin
            depth  = dist_x;
            dist_x = sat_dist(dist_x, r.dx);
            col   += r.xneg ? -1 : 1;
            face   = r.xneg ? gdda_pkg::FACE_COL_NEG : gdda_pkg::FACE_COL_POS;
         end else begin
            depth  = dist_y;
            dist_y = sat_dist(dist_y, r.dy);
            row   += r.yneg ? -1 : 1;
            face   = r.yneg ? gdda_pkg::FACE_ROW_NEG : gdda_pkg::FACE_ROW_POS;
         end
         if (col < 0 || col >= w || row < 0 || row >= hgt) begin
            run.push_back(make_hit(gdda_pkg::HIT_NONE, 0, 0, depth, face));
            done = 1'b1;
         end else begin
            t   = tile_mem[row * GRID + col];
            spr = t[2];
            if (t[1:0] != gdda_pkg::TILE_EMPTY || spr) begin
               // clear wins over sprite, sprite wins over wall
               if (t[1:0] == gdda_pkg::TILE_CLEAR) cls = gdda_pkg::HIT_CLEAR;
               else if (spr) cls = gdda_pkg::HIT_SPRITE;
               else cls = gdda_pkg::HIT_WALL;
               if (cfg_wall && (cls == gdda_pkg::HIT_WALL || cls == gdda_pkg::HIT_CLEAR)) begin
                  run.push_back(make_hit(cls, col, row, depth, face));
                  if (run.size() >= HIT_LIMIT) done = 1'b1;
               end
               if (!done && cfg_wall && cls == gdda_pkg::HIT_WALL) done = 1'b1;
               if (!done && cfg_sprite && spr) begin
                  run.push_back(make_hit(gdda_pkg::HIT_SPRITE, col, row, depth, face));
                  if (run.size() >= HIT_LIMIT) done = 1'b1;
               end
            end
         end
      end
      if (!done && run.size() < HIT_LIMIT)
         run.push_back(make_hit(gdda_pkg::HIT_NONE, 0, 0, depth, face));
      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) pending_hits.push_back(run[i]);
   endfunction

   function automatic ray_req_type tile_req(input logic [5:0] x, input logic [5:0] y,
                                            input logic [1:0] kind, input logic spr);
      ray_req_type r;
      r.rtype = gdda_pkg::REQ_TILE;
      r.cx    = x;
      r.cy    = y;
      r.tkind = kind;
      r.tspr  = spr;
      // cast fields are ignored on a tile write; fill them with noise
      r.sx    = $urandom;
      r.sy    = $urandom;
      r.dx    = $urandom;
      r.dy    = $urandom;
      r.xneg  = 1'($urandom_range(0, 1));
      r.yneg  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic ray_req_type cast_req(input logic [5:0] x, input logic [5:0] y,
                                            input logic [31:0] sx, input logic [31:0] sy,
                                            input logic [31:0] dx, input logic [31:0] dy,
                                            input logic xneg, input logic yneg);
      ray_req_type r;
      r.rtype = gdda_pkg::REQ_CAST;
      r.cx    = x;
      r.cy    = y;
      r.tkind = 2'($urandom_range(0, 3));
      r.tspr  = 1'($urandom_range(0, 1));
      r.sx    = sx;
      r.sy    = sy;
      r.dx    = dx;
      r.dy    = dy;
      r.xneg  = xneg;
      r.yneg  = yneg;
      return r;
   endfunction

   function automatic logic [5:0] pick_coord(input logic [6:0] lim);
      if (lim == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, ((lim > GRID) ? GRID : int'(lim)) - 1));
   endfunction

   function automatic logic [6:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 7'd1;
         1: return 7'd64;
         2: return 7'd0;
         3: return 7'($urandom_range(65, 127));
         default: return 7'($urandom_range(4, 16));
      endcase
   endfunction

   function automatic logic [31:0] rand_dist();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   task automatic send_item(input ray_req_type r);
      int unsigned gap;
      gap = sender_idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= r.rtype;
      req_cell_x      <= r.cx;
      req_cell_y      <= r.cy;
      req_tile_kind   <= r.tkind;
      req_tile_sprite <= r.tspr;
      req_side_x      <= r.sx;
      req_side_y      <= r.sy;
      req_delta_x     <= r.dx;
      req_delta_y     <= r.dy;
      req_step_x_neg  <= r.xneg;
      req_step_y_neg  <= r.yneg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trace_item(r);
      if (r.rtype == gdda_pkg::REQ_CAST) n_casts++;
      else n_tiles++;
   endtask

   // Drop valid, drain every expected hit, then let a trailing tile write finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input gdda_pkg::csr_idx_type idx, input logic [6:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [6:0] w, input logic [6:0] h,
                             input logic wall, input logic spr);
      wait_idle();
      write_reg(gdda_pkg::CSR_MAP_WIDTH, w);
      write_reg(gdda_pkg::CSR_MAP_HEIGHT, h);
      write_reg(gdda_pkg::CSR_WALL_MASK, {6'd0, wall});
      write_reg(gdda_pkg::CSR_SPRITE_MASK, {6'd0, spr});
      csr_we     <= 1'b0;
      cfg_width   = w;
      cfg_height  = h;
      cfg_wall    = wall;
      cfg_sprite  = spr;
      n_settings++;
   endtask

   // Rays through an empty grid under the reset settings: each leaves the grid.
   task automatic test_empty_grid();
      // saturating x distance, then a long run of tied y steps down to the edge
      send_item(cast_req(6'd0, 6'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
                         1'b0, 1'b0));
      send_item(cast_req(6'd30, 6'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'd0, 32'd0, 1'b1, 1'b1));
      send_item(cast_req(6'd63, 6'd63, 32'h0001_2345, 32'h0002_3456, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
   endtask

   task automatic test_tile_classes();
      send_item(tile_req(6'd5, 6'd5, gdda_pkg::TILE_CLEAR, 1'b1));
      send_item(tile_req(6'd7, 6'd5, gdda_pkg::TILE_EMPTY, 1'b1));
      send_item(tile_req(6'd8, 6'd5, gdda_pkg::TILE_WALL, 1'b1));
      send_item(tile_req(6'd9, 6'd5, gdda_pkg::TILE_WALL, 1'b0));
      // overwrite the wall with the illegal kind: must read back as empty
      send_item(tile_req(6'd9, 6'd5, TILE_BAD, 1'b0));
      send_item(tile_req(6'd12, 6'd5, gdda_pkg::TILE_WALL, 1'b0));
      send_item(cast_req(6'd0, 6'd5, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
   endtask

   task automatic test_masks();
      set_config(7'd64, 7'd64, 1'b1, 1'b1);
      send_item(cast_req(6'd0, 6'd5, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
      set_config(7'd64, 7'd64, 1'b0, 1'b1);
      send_item(cast_req(6'd0, 6'd5, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
      set_config(7'd64, 7'd64, 1'b0, 1'b0);
      send_item(cast_req(6'd0, 6'd5, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
   endtask

   task automatic test_map_size();
      // zero width: the first step is already outside
      set_config(7'd0, 7'd64, 1'b1, 1'b0);
      send_item(cast_req(6'd0, 6'd5, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
      // oversize registers clamp to the full grid
      set_config(7'd127, 7'd127, 1'b1, 1'b1);
      send_item(cast_req(6'd0, 6'd5, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000,
                         32'h0001_0000, 1'b0, 1'b0));
      // start row outside a one-row map; only the cell after the step is tested
      set_config(7'd13, 7'd1, 1'b1, 1'b0);
      send_item(cast_req(6'd0, 6'd5, 32'd0, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000,
                         1'b0, 1'b0));
   endtask

   // Clear tiles with sprites give two hits each: eight of them hit the limit.
   task automatic test_hit_limit();
      set_config(7'd64, 7'd64, 1'b1, 1'b1);
      for (int c = 1; c <= 8; c++)
         send_item(tile_req(c[5:0], 6'd9, gdda_pkg::TILE_CLEAR, 1'b1));
      send_item(cast_req(6'd0, 6'd9, 32'd0, 32'hFFFF_FFFF, 32'h0000_C000, 32'd0, 1'b0, 1'b0));
   endtask

   task automatic test_backpressure();
      set_config(7'd16, 7'd16, 1'b1, 1'b1);
      rsp_hold_req <= 1'b1;
      for (int i = 0; i < 12; i++)
         send_item(cast_req(pick_coord(7'd16), pick_coord(7'd16), rand_dist(), rand_dist(),
                            rand_dist(), rand_dist(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [6:0]  w;
      logic [6:0]  hgt;
      ray_req_type r;
      for (int p = 0; p < phases; p++) begin
         w   = pick_size();
         hgt = pick_size();
         set_config(w, hgt, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
         sender_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on    = $urandom_range(0, 3) != 0;
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 9) < 4)
               r = tile_req(pick_coord(w), pick_coord(hgt), 2'($urandom_range(0, 3)),
                            $urandom_range(0, 3) == 0);
            else
               r = cast_req(pick_coord(w), pick_coord(hgt), rand_dist(), rand_dist(),
                            rand_dist(), rand_dist(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            send_item(r);
         end
      end
      sender_idle_on = 1'b1;
      rsp_idle_on    = 1'b1;
   endtask

   // Result pacing: a random gap after each accepted item, or one long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_hold_req) begin
            rsp_hold_left = LONG_HOLD;
            rsp_hold_req <= 1'b0;
         end
         if (rsp_valid && !rsp_stall) rsp_gap_left = rsp_idle_on ? $urandom_range(0, 15) : 0;
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap_left != 0) begin
            rsp_gap_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin : hit_check
      hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            $error("unexpected item: kind %0d at (%0d,%0d)", rsp_hit_kind, rsp_hit_x,
                   rsp_hit_y);
            fail_cnt++;
         end else begin
            want = pending_hits.pop_front();
            check_field("hit_kind", 32'(want.kind), 32'(rsp_hit_kind));
            check_field("hit_x", 32'(want.x), 32'(rsp_hit_x));
            check_field("hit_y", 32'(want.y), 32'(rsp_hit_y));
            check_field("hit_depth", want.depth, rsp_hit_depth);
            check_field("hit_face", 32'(want.face), 32'(rsp_hit_face));
            check_field("last", 32'(want.last), 32'(rsp_last));
            n_hits++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      foreach (tile_mem[i]) tile_mem[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_grid();
      test_tile_classes();
      test_masks();
      test_map_size();
      test_hit_limit();
      test_backpressure();
      test_random_traffic(5, 20);
      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (pending_hits.size() != 0) begin
         $error("%0d expected hits never arrived", pending_hits.size());
         fail_cnt++;
      end
      $display("summary: %0d tile writes and %0d casts sent, %0d hits checked",
               n_tiles, n_casts, n_hits);
      $display("summary: %0d register settings, %0d mismatches", n_settings, fail_cnt);
      if (fail_cnt == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
